@@ rtl/ats_pkg.sv @@
// Shared types, constants and sizes for the arrival timing statistics block.
package ats_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned MEAN_W     = 56;
  localparam int unsigned VAR_W      = 64;
  localparam int unsigned SAMPLE_W   = 40;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned INIT_W     = 24;
  localparam int unsigned THRESH_W   = 28;
  localparam int unsigned CFG_DATA_W = 28;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 232;

  localparam logic [COUNT_W-1:0] SKIP_MESSAGES   = 5'd4;
  localparam logic [COUNT_W-1:0] WARMUP_MESSAGES = 5'd16;

  localparam logic [INIT_W-1:0]   INIT_LAT_MEAN_RST = 24'd200000;
  localparam logic [THRESH_W-1:0] THRESH_RST        = 28'd3000000;

  localparam logic [VAR_W-1:0] VAR_MAX   = {48'hFFFF_FFFF_FFFF, 16'h0000};
  // offset that keeps a signed mean step positive ahead of the /5 stage
  localparam logic [VAR_W-1:0] MEAN_BIAS = 64'h0500_0000_0000_0000;
  localparam logic [VAR_W-1:0] STEP_BIAS = 64'h0100_0000_0000_0000;

  typedef enum logic {
    CFG_INIT_LAT_MEAN = 1'b0,
    CFG_TIME_THRESH   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MEAN,
    ST_DIV_MEAN,
    ST_SQ,
    ST_MUL,
    ST_VAR,
    ST_DIV_VAR,
    ST_IVL_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ rtl/ats_div5.sv @@
// Radix-16 digit-serial unsigned divide by five over a 64-bit word.
module ats_div5 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ats_pkg::VAR_W-1:0]   dividend_i,
  output logic [ats_pkg::VAR_W-1:0]   quotient_o,
  output ats_pkg::unit_sts_t          sts_o
);

  localparam int unsigned Digits = ats_pkg::VAR_W / ats_pkg::DIGIT_W;
  localparam int unsigned CntW   = $clog2(Digits);

  logic [ats_pkg::VAR_W-1:0] work_q;
  logic [2:0]                rem_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [6:0]                partial;
  logic [ats_pkg::DIGIT_W+2:0] step;

  // restoring divide of a value below 80 by five: quotient digit and remainder
  function automatic logic [6:0] div5_digit(input logic [6:0] v);
    logic [6:0] r;
    logic [3:0] q;
    r = v;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      if (r >= 7'(5 << i)) begin
        r    = r - 7'(5 << i);
        q[i] = 1'b1;
      end
    end
    return {q, r[2:0]};
  endfunction

  assign partial = {rem_q, work_q[ats_pkg::VAR_W-1 -: ats_pkg::DIGIT_W]};
  assign step    = div5_digit(partial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Digits - 1);
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= step[2:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
    end else if (busy_q) begin
      work_q <= {work_q[ats_pkg::VAR_W-ats_pkg::DIGIT_W-1:0], step[6:3]};
    end
  end

  assign quotient_o = work_q;
  assign sts_o      = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/ats_sqr.sv @@
// Radix-16 digit-serial squarer for a 40-bit magnitude.
module ats_sqr (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ats_pkg::SAMPLE_W-1:0]   a_i,
  output logic [2*ats_pkg::SAMPLE_W-1:0] product_o,
  output ats_pkg::unit_sts_t             sts_o
);

  localparam int unsigned AW     = ats_pkg::SAMPLE_W;
  localparam int unsigned PW     = 2 * AW;
  localparam int unsigned Digits = AW / ats_pkg::DIGIT_W;
  localparam int unsigned CntW   = $clog2(Digits);

  logic [AW-1:0]   mcand_q;
  logic [AW-1:0]   mplier_q;
  logic [PW-1:0]   acc_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [AW+ats_pkg::DIGIT_W-1:0] pp;

  assign pp = mcand_q * mplier_q[AW-1 -: ats_pkg::DIGIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Digits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // most significant multiplier digit first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= a_i;
      mplier_q <= a_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      mplier_q <= {mplier_q[AW-ats_pkg::DIGIT_W-1:0], {ats_pkg::DIGIT_W{1'b0}}};
      acc_q    <= {acc_q[PW-ats_pkg::DIGIT_W-1:0], {ats_pkg::DIGIT_W{1'b0}}} + PW'(pp);
    end
  end

  assign product_o = acc_q;
  assign sts_o     = '{busy: busy_q, done: done_q};

endmodule

@@ rtl/arrival_timing_statistics.sv @@
// Top level: moving mean and variance of message latency and arrival interval.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  request   | s_axis_tvalid/s_axis_tready| s_axis_tdata: arrival, measurement
//  result    | m_axis_tvalid/m_axis_tready| m_axis_tdata: means, variances, flags
//  config    | cfg_we_i (no wait)         | cfg_addr_i, cfg_wdata_i
//
// One request at a time. A skipped request goes from prep straight to done; a warm-up
// request moves each mean halfway to its sample. A full request runs, per updated stream,
// the radix-16 divide by five twice and the radix-16 squarer at most once.
// A finished result waits in the output register while the next request runs.
// Reset loads the register and statistics reset values at once; no clearing pass.
module arrival_timing_statistics (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [47:0] arrival_time_us, [95:48] measurement_time_us
  input  logic [ats_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [39:0] latency_mean_us, [87:40] latency_variance, [127:88] interval_mean_us,
  // [175:128] interval_variance, [223:176] latest_measurement_us,
  // [224] negative_interval, [225] time_was_reset, [230:226] messages_seen, [231] 0
  output logic [ats_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic                               cfg_addr_i,
  input  logic [ats_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned TW = ats_pkg::TIME_W;
  localparam int unsigned MW = ats_pkg::MEAN_W;
  localparam int unsigned VW = ats_pkg::VAR_W;
  localparam int unsigned SW = ats_pkg::SAMPLE_W;
  localparam int unsigned CW = ats_pkg::COUNT_W;

  ats_pkg::state_e state_q, state_d;

  logic [ats_pkg::INIT_W-1:0]   init_mean_q;
  logic [ats_pkg::THRESH_W-1:0] thresh_q;
  logic signed [MW-1:0]         lat_mean_q, ivl_mean_q;
  logic [VW-1:0]                lat_var_q, ivl_var_q;
  logic [TW-1:0]                prev_arr_q, newest_q;
  logic [CW-1:0]                count_q;

  logic [TW-1:0]        arr_q, meas_q;
  logic                 run_q, warm_q, neg_q, rst_flag_q, ch_q, up_q;
  logic signed [MW-1:0] x_lat_q, x_ivl_q;
  logic [VW-1:0]        term_q;

  logic                          out_valid_q;
  logic [ats_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                 accept, load_out;
  logic                 div_start, sq_start;
  logic [VW-1:0]        div_op, quotient;
  logic [2*SW-1:0]      product;
  ats_pkg::unit_sts_t   div_sts, sq_sts;

  logic signed [MW-1:0] mean_sel, x_sel;
  logic [VW-1:0]        var_sel;
  logic signed [MW:0]   diff, half_sum;
  logic [MW:0]          mag;
  logic                 big;
  logic [VW-1:0]        div_mean_op, div_var_op, mean_step, sum_down, sq_term;
  logic [VW-1:0]        var_up_diff;
  logic signed [MW+1:0] two_x, three_m, m_ext;
  logic                 band;
  logic signed [TW:0]   lat_raw;
  logic [TW-1:0]        ivl_raw;
  logic [SW-1:0]        lat_sample, ivl_sample;
  logic signed [TW+1:0] meas_ext, floor_ext;
  logic                 time_reset;

  // ---------------------------------------------------------------- datapath helpers
  always_comb begin
    mean_sel = ch_q ? ivl_mean_q : lat_mean_q;
    var_sel  = ch_q ? ivl_var_q : lat_var_q;
    x_sel    = ch_q ? x_ivl_q : x_lat_q;

    diff     = {x_sel[MW-1], x_sel} - {mean_sel[MW-1], mean_sel};
    half_sum = {mean_sel[MW-1], mean_sel} + (diff >>> 1);
    div_mean_op = {{(VW-MW+1){diff[MW]}}, diff[MW:2]} + ats_pkg::MEAN_BIAS;
    mean_step   = quotient - ats_pkg::STEP_BIAS;

    mag = diff[MW] ? (MW+1)'(-diff) : diff;
    big = |mag[MW:SW];

    var_up_diff = term_q - var_sel;
    sum_down    = (var_sel - term_q) + VW'(19);
    div_var_op  = (term_q >= var_sel) ? {2'b00, var_up_diff[VW-1:2]}
                                      : {2'b00, sum_down[VW-1:2]};
    div_op      = (state_q == ats_pkg::ST_MEAN) ? div_mean_op : div_var_op;

    sq_term = (product[2*SW-1:ats_pkg::FRAC_W] > ats_pkg::VAR_MAX) ?
              ats_pkg::VAR_MAX : product[2*SW-1:ats_pkg::FRAC_W];

    two_x   = {x_ivl_q[MW-1], x_ivl_q, 1'b0};
    m_ext   = {{2{ivl_mean_q[MW-1]}}, ivl_mean_q};
    three_m = m_ext + {ivl_mean_q[MW-1], ivl_mean_q, 1'b0};
    band    = (two_x > m_ext) && (two_x < three_m);

    lat_raw = {1'b0, arr_q} - {1'b0, meas_q};
    if (lat_raw[TW:SW-1] == '0 || lat_raw[TW:SW-1] == '1) begin
      lat_sample = lat_raw[SW-1:0];
    end else begin
      lat_sample = {lat_raw[TW], {(SW-1){~lat_raw[TW]}}};
    end
    ivl_raw    = arr_q - prev_arr_q;
    ivl_sample = (ivl_raw[TW-1:SW-1] == '0) ? ivl_raw[SW-1:0] : {1'b0, {(SW-1){1'b1}}};

    meas_ext   = {2'b00, meas_q};
    floor_ext  = {2'b00, newest_q} - {{(TW-ats_pkg::THRESH_W+2){1'b0}}, thresh_q};
    time_reset = meas_ext < floor_ext;
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ats_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ats_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ats_pkg::ST_PREP;
        end
      end
      ats_pkg::ST_PREP: begin
        state_d = run_q ? ats_pkg::ST_MEAN : ats_pkg::ST_DONE;
      end
      ats_pkg::ST_MEAN: begin
        if (warm_q) begin
          state_d = ch_q ? ats_pkg::ST_DONE : ats_pkg::ST_IVL_CHECK;
        end else begin
          div_start = 1'b1;
          state_d   = ats_pkg::ST_DIV_MEAN;
        end
      end
      ats_pkg::ST_DIV_MEAN: begin
        if (div_sts.done) begin
          state_d = ats_pkg::ST_SQ;
        end
      end
      ats_pkg::ST_SQ: begin
        if (big) begin
          state_d = ats_pkg::ST_VAR;
        end else begin
          sq_start = 1'b1;
          state_d  = ats_pkg::ST_MUL;
        end
      end
      ats_pkg::ST_MUL: begin
        if (sq_sts.done) begin
          state_d = ats_pkg::ST_VAR;
        end
      end
      ats_pkg::ST_VAR: begin
        div_start = 1'b1;
        state_d   = ats_pkg::ST_DIV_VAR;
      end
      ats_pkg::ST_DIV_VAR: begin
        if (div_sts.done) begin
          state_d = ch_q ? ats_pkg::ST_DONE : ats_pkg::ST_IVL_CHECK;
        end
      end
      ats_pkg::ST_IVL_CHECK: begin
        state_d = (!neg_q && (warm_q || band)) ? ats_pkg::ST_MEAN : ats_pkg::ST_DONE;
      end
      ats_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ats_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ats_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_mean_q <= ats_pkg::INIT_LAT_MEAN_RST;
      thresh_q    <= ats_pkg::THRESH_RST;
      lat_mean_q  <= {{(MW-ats_pkg::INIT_W-ats_pkg::FRAC_W){1'b0}},
                      ats_pkg::INIT_LAT_MEAN_RST, {ats_pkg::FRAC_W{1'b0}}};
      lat_var_q   <= '0;
      ivl_mean_q  <= '0;
      ivl_var_q   <= '0;
      prev_arr_q  <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      run_q       <= 1'b0;
      warm_q      <= 1'b0;
      neg_q       <= 1'b0;
      rst_flag_q  <= 1'b0;
      ch_q        <= 1'b0;
      up_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ats_pkg::CFG_INIT_LAT_MEAN: begin
            init_mean_q <= cfg_wdata_i[ats_pkg::INIT_W-1:0];
            if (count_q <= ats_pkg::SKIP_MESSAGES) begin
              lat_mean_q <= {{(MW-ats_pkg::INIT_W-ats_pkg::FRAC_W){1'b0}},
                             cfg_wdata_i[ats_pkg::INIT_W-1:0], {ats_pkg::FRAC_W{1'b0}}};
            end
          end
          ats_pkg::CFG_TIME_THRESH: begin
            thresh_q <= cfg_wdata_i[ats_pkg::THRESH_W-1:0];
          end
          default: begin
            thresh_q <= thresh_q;
          end
        endcase
      end

      case (state_q)
        ats_pkg::ST_IDLE: begin
          if (accept) begin
            run_q  <= count_q > ats_pkg::SKIP_MESSAGES;
            warm_q <= count_q < ats_pkg::WARMUP_MESSAGES;
            if (count_q < ats_pkg::WARMUP_MESSAGES) begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        ats_pkg::ST_PREP: begin
          neg_q      <= run_q && (arr_q < prev_arr_q);
          prev_arr_q <= arr_q;
          rst_flag_q <= time_reset;
          if (time_reset || (newest_q < meas_q)) begin
            newest_q <= meas_q;
          end
          ch_q <= 1'b0;
        end
        ats_pkg::ST_MEAN: begin
          if (warm_q) begin
            if (ch_q) ivl_mean_q <= half_sum[MW-1:0];
            else      lat_mean_q <= half_sum[MW-1:0];
          end
        end
        ats_pkg::ST_DIV_MEAN: begin
          if (div_sts.done) begin
            if (ch_q) ivl_mean_q <= ivl_mean_q + mean_step[MW-1:0];
            else      lat_mean_q <= lat_mean_q + mean_step[MW-1:0];
          end
        end
        ats_pkg::ST_DIV_VAR: begin
          if (div_sts.done) begin
            if (ch_q) ivl_var_q <= up_q ? ivl_var_q + quotient : ivl_var_q - quotient;
            else      lat_var_q <= up_q ? lat_var_q + quotient : lat_var_q - quotient;
          end
        end
        ats_pkg::ST_VAR: begin
          up_q <= term_q >= var_sel;
        end
        ats_pkg::ST_IVL_CHECK: begin
          ch_q <= 1'b1;
        end
        default: begin
          ch_q <= ch_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      arr_q  <= s_axis_tdata[TW-1:0];
      meas_q <= s_axis_tdata[2*TW-1:TW];
    end
    if (state_q == ats_pkg::ST_PREP) begin
      x_lat_q <= {lat_sample, {ats_pkg::FRAC_W{1'b0}}};
      x_ivl_q <= {ivl_sample, {ats_pkg::FRAC_W{1'b0}}};
    end
    if (state_q == ats_pkg::ST_SQ && big) begin
      term_q <= ats_pkg::VAR_MAX;
    end else if (state_q == ats_pkg::ST_MUL && sq_sts.done) begin
      term_q <= sq_term;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {1'b0, count_q, rst_flag_q, neg_q, newest_q,
                     ivl_var_q[VW-1:ats_pkg::FRAC_W], ivl_mean_q[MW-1:ats_pkg::FRAC_W],
                     lat_var_q[VW-1:ats_pkg::FRAC_W], lat_mean_q[MW-1:ats_pkg::FRAC_W]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------- serial units
  ats_div5 u_div5 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_op),
    .quotient_o (quotient),
    .sts_o      (div_sts)
  );

  ats_sqr u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .a_i       (mag[SW-1:0]),
    .product_o (product),
    .sts_o     (sq_sts)
  );

`ifndef SYNTHESIS
  a_units_idle_on_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!div_sts.busy && !sq_sts.busy))
    else $error("serial unit busy while taking a request");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ats_pkg::ST_DIV_MEAN || state_q == ats_pkg::ST_DIV_VAR))
    else $error("divider finished outside a divide step");

  a_sq_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_sts.done |-> (state_q == ats_pkg::ST_MUL))
    else $error("squarer finished outside the multiply step");

  a_var_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lat_var_q <= ats_pkg::VAR_MAX) && (ivl_var_q <= ats_pkg::VAR_MAX))
    else $error("variance above saturation limit");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ats_pkg::WARMUP_MESSAGES)
    else $error("message count past warm-up limit");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the arrival timing statistics block: latency and interval statistics.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TW = ats_pkg::TIME_W;
  localparam int unsigned VW = ats_pkg::VAR_W;
  localparam int unsigned FW = ats_pkg::FRAC_W;
  localparam int unsigned DW = ats_pkg::CFG_DATA_W;

  localparam longint SAMPLE_HI    = 64'sd549755813887;
  localparam longint SAMPLE_LO    = -64'sd549755813888;
  localparam int     PHASE_ITEMS  = 106;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     TAIL_CYCLES  = 150;
  localparam logic [TW-1:0] TIME_MAX = '1;

  typedef struct {
    logic [TW-1:0] arrival;
    logic [TW-1:0] meas;
  } timing_req_t;

  typedef struct {
    logic [39:0]                 lat_mean;
    logic [47:0]                 lat_var;
    logic [39:0]                 ivl_mean;
    logic [47:0]                 ivl_var;
    logic [TW-1:0]               newest;
    logic                        neg_ivl;
    logic                        time_rst;
    logic [ats_pkg::COUNT_W-1:0] seen;
  } timing_stats_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // [47:0] arrival_time_us, [95:48] measurement_time_us
  logic [ats_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [39:0] latency_mean_us, [87:40] latency_variance, [127:88] interval_mean_us,
  // [175:128] interval_variance, [223:176] latest_measurement_us,
  // [224] negative_interval, [225] time_was_reset, [230:226] messages_seen
  logic [ats_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we_i = 1'b0;
  logic                           cfg_addr_i = 1'b0;
  logic [DW-1:0]                  cfg_wdata_i = '0;

  arrival_timing_statistics u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [ats_pkg::INIT_W-1:0]   cfg_init_mean = ats_pkg::INIT_LAT_MEAN_RST;
  logic [ats_pkg::THRESH_W-1:0] cfg_threshold = ats_pkg::THRESH_RST;
  longint                       lat_mean_q = longint'(ats_pkg::INIT_LAT_MEAN_RST) * 65536;
  logic [VW-1:0]                lat_var_q = '0;
  longint                       ivl_mean_q = 0;
  logic [VW-1:0]                ivl_var_q = '0;
  logic [TW-1:0]                prev_arrival = '0;
  logic [TW-1:0]                newest_meas = '0;
  logic [ats_pkg::COUNT_W-1:0]  msg_count = '0;

  timing_req_t   pending_reqs[$];
  timing_stats_t expected_stats[$];
  int            mismatches = 0;
  int            hold_requests = 0;

  function automatic longint div_floor(longint v, longint d);
    longint q;
    q = v / d;
    if (v < 0 && q * d != v) q = q - 1;
    return q;
  endfunction

  function automatic longint saturate_sample(longint v);
    if (v > SAMPLE_HI) return SAMPLE_HI;
    if (v < SAMPLE_LO) return SAMPLE_LO;
    return v;
  endfunction

  // floor(d*d / 2^16), capped at the variance ceiling
  function automatic logic [VW-1:0] square_q16(longint d);
    logic [63:0]  a;
    logic [127:0] p;
    a = (d < 0) ? -d : d;
    if (a >= (64'd1 << 40)) return ats_pkg::VAR_MAX;
    p = a * a;
    p = p >> FW;
    if (p > {64'd0, ats_pkg::VAR_MAX}) return ats_pkg::VAR_MAX;
    return p[63:0];
  endfunction

  function automatic logic [VW-1:0] var_step(logic [VW-1:0] v, logic [VW-1:0] t);
    if (t >= v) return v + (t - v) / 20;
    return v - ((v - t) + 19) / 20;
  endfunction

  task automatic ema_update(inout longint m, inout logic [VW-1:0] v, input longint x_us,
                            input bit warm);
    longint x;
    x = x_us * 65536;
    if (warm) begin
      m = m + div_floor(x - m, 2);
    end else begin
      m = m + div_floor(x - m, 20);
      v = var_step(v, square_q16(x - m));
    end
  endtask

  task automatic advance_stats(input logic [TW-1:0] arrival, input logic [TW-1:0] meas);
    timing_stats_t r;
    longint        x;
    logic [63:0]   shifted;
    bit            warm;
    r.neg_ivl  = 1'b0;
    r.time_rst = 1'b0;
    if (msg_count > ats_pkg::SKIP_MESSAGES) begin
      warm = msg_count < ats_pkg::WARMUP_MESSAGES;
      ema_update(lat_mean_q, lat_var_q,
                 saturate_sample(longint'(arrival) - longint'(meas)), warm);
      if (arrival < prev_arrival) begin
        r.neg_ivl = 1'b1;
      end else begin
        x = saturate_sample(longint'(arrival - prev_arrival));
        if (warm) begin
          ema_update(ivl_mean_q, ivl_var_q, x, 1'b1);
        end else if (2 * x * 65536 > ivl_mean_q && 2 * x * 65536 < 3 * ivl_mean_q) begin
          ema_update(ivl_mean_q, ivl_var_q, x, 1'b0);
        end
      end
    end
    prev_arrival = arrival;
    if (longint'(meas) < longint'(newest_meas) - longint'(cfg_threshold)) begin
      newest_meas = meas;
      r.time_rst  = 1'b1;
    end else if (newest_meas < meas) begin
      newest_meas = meas;
    end
    if (msg_count < ats_pkg::WARMUP_MESSAGES) msg_count = msg_count + 1'b1;
    shifted    = lat_mean_q >>> FW;
    r.lat_mean = shifted[39:0];
    shifted    = ivl_mean_q >>> FW;
    r.ivl_mean = shifted[39:0];
    r.lat_var  = lat_var_q[63:16];
    r.ivl_var  = ivl_var_q[63:16];
    r.newest   = newest_meas;
    r.seen     = msg_count;
    expected_stats.insert(expected_stats.size(), r);
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  // request driver: bursts with random gaps
  timing_req_t next_req;
  int          burst_left;
  int          gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        advance_stats(s_axis_tdata[TW-1:0], s_axis_tdata[2*TW-1:TW]);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered request
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs[0];
        pending_reqs.delete(0);
        s_axis_tdata  <= {next_req.meas, next_req.arrival};
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 120);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink: a randomly redrawn stall pattern, plus requested long hold-offs
  int       cycle_no;
  int       hold_served;
  int       hold_left;
  int       rx_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      cycle_no    = 0;
      hold_served = 0;
      hold_left   = 0;
      rx_mode     = 0;
    end else begin
      cycle_no++;
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (cycle_no % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (cycle_no % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result checker
  timing_stats_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_stats.size() == 0) begin
        check_field("unexpected result", 64'd1, 64'd0);
      end else begin
        want = expected_stats[0];
        expected_stats.delete(0);
        check_field("latency_mean_us", 64'(m_axis_tdata[39:0]), 64'(want.lat_mean));
        check_field("latency_variance", 64'(m_axis_tdata[87:40]), 64'(want.lat_var));
        check_field("interval_mean_us", 64'(m_axis_tdata[127:88]), 64'(want.ivl_mean));
        check_field("interval_variance", 64'(m_axis_tdata[175:128]), 64'(want.ivl_var));
        check_field("latest_measurement_us", 64'(m_axis_tdata[223:176]),
                    64'(want.newest));
        check_field("negative_interval", 64'(m_axis_tdata[224]), 64'(want.neg_ivl));
        check_field("time_was_reset", 64'(m_axis_tdata[225]), 64'(want.time_rst));
        check_field("messages_seen", 64'(m_axis_tdata[230:226]), 64'(want.seen));
      end
    end
  end

  task automatic queue_req(input logic [TW-1:0] arrival, input logic [TW-1:0] meas);
    timing_req_t r;
    r.arrival = arrival;
    r.meas    = meas;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(input ats_pkg::cfg_idx_e idx, input logic [DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      ats_pkg::CFG_INIT_LAT_MEAN: begin
        cfg_init_mean = value[ats_pkg::INIT_W-1:0];
        if (msg_count <= ats_pkg::SKIP_MESSAGES) lat_mean_q = longint'(cfg_init_mean) * 65536;
      end
      ats_pkg::CFG_TIME_THRESH: cfg_threshold = value[ats_pkg::THRESH_W-1:0];
      default: cfg_threshold = cfg_threshold;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TW-1:0];
  endfunction

  initial begin
    logic [TW-1:0] t;
    logic [TW-1:0] meas;
    int            n;
    int            seq_len;
    int            lat_base;
    int            lat;
    int            k;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: skipped messages, early register loads
    write_reg(ats_pkg::CFG_INIT_LAT_MEAN, '1);
    write_reg(ats_pkg::CFG_TIME_THRESH, '0);
    t = 48'd5000000;
    queue_req('0, '0);
    queue_req(TIME_MAX, TIME_MAX);
    wait_idle();
    write_reg(ats_pkg::CFG_INIT_LAT_MEAN, '0);
    queue_req(t - 2000, t - 2300);
    queue_req(t - 1000, t - 1300);
    wait_idle();
    write_reg(ats_pkg::CFG_INIT_LAT_MEAN, 28'd200);
    write_reg(ats_pkg::CFG_TIME_THRESH, '1);

    // warm-up, with one backwards arrival and a late mean register write
    for (int i = 0; i < 12; i++) begin
      if (i == 2) begin
        queue_req(t - 500, t - 800);
      end else begin
        t = t + 1000;
        queue_req(t, t - 300 - 10 * i);
      end
      if (i == 6) begin
        wait_idle();
        write_reg(ats_pkg::CFG_INIT_LAT_MEAN, 28'hFFFFFF);
      end
    end

    // steady state corner cases
    t = t + 1000;
    queue_req(t, t - 300);
    t = t + 3000;
    queue_req(t, t - 300);          // irregular interval
    queue_req(t - 200, t - 400);    // backwards arrival
    t = t + 1000;
    queue_req(t, t - 300);
    queue_req(TIME_MAX, '0);        // latency and squared deviation saturate
    queue_req(48'd1000, TIME_MAX);  // negative latency saturates
    t = t + 1000;
    queue_req(t, t - 300);          // old timestamp resets the latest time
    t = t + 1000;
    queue_req(t, t - 300);
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(ats_pkg::CFG_INIT_LAT_MEAN, '0);
          write_reg(ats_pkg::CFG_TIME_THRESH, ats_pkg::THRESH_RST);
        end
        1: begin
          write_reg(ats_pkg::CFG_INIT_LAT_MEAN, 28'hFFFFFF);
          write_reg(ats_pkg::CFG_TIME_THRESH, '0);
        end
        2: begin
          write_reg(ats_pkg::CFG_INIT_LAT_MEAN, DW'($urandom_range(0, 24'hFFFFFF)));
          write_reg(ats_pkg::CFG_TIME_THRESH, 28'hFFFFFFF);
        end
        3: begin
          write_reg(ats_pkg::CFG_INIT_LAT_MEAN, DW'($urandom_range(0, 28'hFFFFFFF)));
          write_reg(ats_pkg::CFG_TIME_THRESH, DW'($urandom_range(0, 28'hFFFFFFF)));
        end
        default: begin
          write_reg(ats_pkg::CFG_INIT_LAT_MEAN, DW'(ats_pkg::INIT_LAT_MEAN_RST));
          write_reg(ats_pkg::CFG_TIME_THRESH, DW'($urandom_range(0, 5000)));
        end
      endcase

      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          // regular stream with random content
          seq_len  = $urandom_range(4, 24);
          lat_base = $urandom_range(0, 5000);
          if ($urandom_range(0, 1)) t = rand_time();
          for (int j = 0; j < seq_len && n < PHASE_ITEMS; j++) begin
            t   = t + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                   : $urandom_range(800, 1200));
            lat = lat_base + $urandom_range(0, 400);
            k   = $urandom_range(0, 19);
            if (k == 0) meas = t + $urandom_range(0, 3000);
            else if (k == 1) meas = rand_time();
            else meas = (t > lat) ? t - lat : '0;
            queue_req(t, meas);
            n++;
          end
        end else begin
          queue_req(rand_time(), rand_time());
          n++;
        end
      end
      if (phase == 1) hold_requests++;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ats_pkg.sv
rtl/ats_div5.sv
rtl/ats_sqr.sv
rtl/arrival_timing_statistics.sv
tb/tb.sv
